// ===== hw/rtl/dtd_pkg.sv =====
// Shared types, constants and calendar tables for the date text to day number block.
// Used by dtd_parse, dtd_calc, dtd_sum and date_text_to_day_number.
// No dependencies.
package dtd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned FieldW = 7;
  localparam int unsigned CountW = 22;

  // Largest year accepted; the year saturates here
  localparam logic [YearW-1:0] MaxYear = YearW'(9999);
  // Reset value of the minimum year register
  localparam logic [YearW-1:0] MinYearReset = YearW'(1900);

  // Character codes
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  // Reciprocal of 100 scaled by 2^19; exact floor for values below 43699
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned Recip100Sh = 19;

  // Date gathered by the parser, with all checks that need no calendar math
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic              ok;
  } dtd_date_t;

  // Partial products for the day count
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [YearW-1:0]  prev_year;
    logic [3:0]        month;
    logic [FieldW-1:0] day;
    logic [6:0]        year_div100;
    logic [6:0]        prev_div100;
    logic [CountW-1:0] prev_x365;
    logic              ok;
  } dtd_part_t;

  // Length of a month in a common year; 0 for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of a month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] sum;
    case (m)
      4'd2:    sum = 9'd31;
      4'd3:    sum = 9'd59;
      4'd4:    sum = 9'd90;
      4'd5:    sum = 9'd120;
      4'd6:    sum = 9'd151;
      4'd7:    sum = 9'd181;
      4'd8:    sum = 9'd212;
      4'd9:    sum = 9'd243;
      4'd10:   sum = 9'd273;
      4'd11:   sum = 9'd304;
      4'd12:   sum = 9'd334;
      default: sum = 9'd0;
    endcase
    return sum;
  endfunction

endpackage

// ===== hw/rtl/date_text_to_day_number.sv =====
// Date text to day number: converts a YYYY-MM-DD character stream into a Gregorian day number.
// Top level; instantiates dtd_parse, dtd_calc and dtd_sum. Depends on dtd_pkg.
//
// Characters arrive one per transfer on the slave stream, tlast on the final one, and the
// block takes one character every cycle unless stalled. Each string yields one result on the
// master stream, held in turn in the parser register, the quotient and product register, and
// the result register. Every stage holds its item under backpressure and takes a new one as
// soon as its own is passed on, so up to three results may wait in flight while the master
// side stalls. tuser is 1 for a well-formed date between the year floor and 9999 with a real
// month and day (leap years counted); tdata then holds the day number with 0001-01-01 as day
// 1, and 0 otherwise. The floor resets to 1900 and is written via cfg_we_i / cfg_wdata_i;
// the user must write it only while no string is in progress; the block does not check this.
module date_text_to_day_number
  import dtd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration: minimum year
  input  logic              cfg_we_i,
  input  logic [YearW-1:0]  cfg_wdata_i,
  // Character stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] ch
  input  logic              s_axis_tlast,
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [21:0] day_count, [23:22] zero
  output logic              m_axis_tuser    // [0] valid_res
);

  logic [YearW-1:0]  year_floor_q;
  logic              date_vld, date_rdy;
  dtd_date_t         date;
  logic              part_vld, part_rdy;
  dtd_part_t         part;
  logic [CountW-1:0] day_count;

  // Hold the minimum year register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_floor_q <= MinYearReset;
    end else if (cfg_we_i) begin
      year_floor_q <= cfg_wdata_i;
    end
  end

  dtd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .year_floor_i (year_floor_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .ch_i         (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .out_valid_o  (date_vld),
    .out_ready_i  (date_rdy),
    .out_date_o   (date)
  );

  dtd_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (date_vld),
    .in_ready_o  (date_rdy),
    .in_date_i   (date),
    .out_valid_o (part_vld),
    .out_ready_i (part_rdy),
    .out_part_o  (part)
  );

  dtd_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (part_vld),
    .in_ready_o  (part_rdy),
    .in_part_i   (part),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .valid_res_o (m_axis_tuser),
    .day_count_o (day_count)
  );

  assign m_axis_tdata = {2'b00, day_count};

endmodule

// ===== hw/rtl/dtd_parse.sv =====
// Character parser: tracks the position in the date string and gathers year, month, day.
// Captures the finished date into an output register on the last character.
// Depends on dtd_pkg.
module dtd_parse
  import dtd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [YearW-1:0]    year_floor_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtd_date_t           out_date_o
);

  typedef enum logic [2:0] {
    PhYear  = 3'd0,
    PhMon1  = 3'd1,
    PhMon2  = 3'd2,
    PhDash2 = 3'd3,
    PhDay1  = 3'd4,
    PhDay2  = 3'd5,
    PhDone  = 3'd6
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [YearW-1:0]  year_q, year_d;
  logic              too_big_q, too_big_d;
  logic              have_dig_q, have_dig_d;
  logic [FieldW-1:0] month_q, month_d;
  logic [FieldW-1:0] day_q, day_d;
  logic              err_q, err_d;
  logic              vld_q;
  dtd_date_t         date_q, date_d;

  logic              dig;
  logic [3:0]        dval;
  logic [16:0]       year_ext;
  logic [FieldW-1:0] dval_x10;
  logic              accept;

  assign dig      = ch_i inside {[ChZero:ChNine]};
  assign dval     = dig ? ch_i[3:0] : 4'd0;
  assign year_ext = 17'(year_q) * 17'd10 + 17'(dval);
  assign dval_x10 = FieldW'(dval) * FieldW'(10);

  // Slot is free when empty or draining this cycle
  assign in_ready_o = !vld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next parse state for the current character
  always_comb begin
    phase_d    = phase_q;
    year_d     = year_q;
    too_big_d  = too_big_q;
    have_dig_d = have_dig_q;
    month_d    = month_q;
    day_d      = day_q;
    err_d      = err_q;
    if (!err_q) begin
      case (phase_q)
        PhYear: begin
          if (dig) begin
            have_dig_d = 1'b1;
            if (too_big_q || year_ext > 17'(MaxYear)) begin
              too_big_d = 1'b1;
              year_d    = MaxYear;
            end else begin
              year_d = year_ext[YearW-1:0];
            end
          end else if (ch_i == ChDash && have_dig_q) begin
            phase_d = PhMon1;
          end else begin
            err_d = 1'b1;
          end
        end
        PhMon1: begin
          if (dig) begin
            month_d = dval_x10;
            phase_d = PhMon2;
          end else begin
            err_d = 1'b1;
          end
        end
        PhMon2: begin
          if (dig) begin
            month_d = month_q + FieldW'(dval);
            phase_d = PhDash2;
          end else begin
            err_d = 1'b1;
          end
        end
        PhDash2: begin
          if (ch_i == ChDash) begin
            phase_d = PhDay1;
          end else begin
            err_d = 1'b1;
          end
        end
        PhDay1: begin
          if (dig) begin
            day_d   = dval_x10;
            phase_d = PhDay2;
          end else begin
            err_d = 1'b1;
          end
        end
        PhDay2: begin
          if (dig) begin
            day_d   = day_q + FieldW'(dval);
            phase_d = PhDone;
          end else begin
            err_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks that need no calendar arithmetic
  always_comb begin
    date_d.year  = year_d;
    date_d.month = month_d;
    date_d.day   = day_d;
    date_d.ok    = !err_d && phase_d == PhDone && !too_big_d &&
                   year_d != '0 && year_d >= year_floor_i &&
                   month_d >= FieldW'(1) && month_d <= FieldW'(12) &&
                   day_d != '0;
  end

  // Parse state: advance on each transfer, clear after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhYear;
      year_q     <= '0;
      too_big_q  <= 1'b0;
      have_dig_q <= 1'b0;
      month_q    <= '0;
      day_q      <= '0;
      err_q      <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        phase_q    <= PhYear;
        year_q     <= '0;
        too_big_q  <= 1'b0;
        have_dig_q <= 1'b0;
        month_q    <= '0;
        day_q      <= '0;
        err_q      <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        year_q     <= year_d;
        too_big_q  <= too_big_d;
        have_dig_q <= have_dig_d;
        month_q    <= month_d;
        day_q      <= day_d;
        err_q      <= err_d;
      end
    end
  end

  // Output slot: load on the last character, empty when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= accept && last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      date_q <= date_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_date_o  = date_q;

endmodule

// ===== hw/rtl/dtd_calc.sv =====
// First arithmetic stage: quotients by 100 and the 365-day product of the elapsed years.
// Depends on dtd_pkg.
module dtd_calc
  import dtd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dtd_date_t in_date_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dtd_part_t out_part_o
);

  logic             vld_q;
  dtd_part_t        part_q, part_d;
  logic [YearW-1:0] prev_year;
  logic [26:0]      year_prod;
  logic [26:0]      prev_prod;

  assign prev_year = in_date_i.year - YearW'(1);
  assign year_prod = 27'(in_date_i.year) * 27'(Recip100);
  assign prev_prod = 27'(prev_year) * 27'(Recip100);

  // Divide by 100 through the scaled reciprocal
  always_comb begin
    part_d.year        = in_date_i.year;
    part_d.prev_year   = prev_year;
    part_d.month       = in_date_i.month[3:0];
    part_d.day         = in_date_i.day;
    part_d.year_div100 = year_prod[Recip100Sh +: 7];
    part_d.prev_div100 = prev_prod[Recip100Sh +: 7];
    part_d.prev_x365   = CountW'(prev_year) * CountW'(365);
    part_d.ok          = in_date_i.ok;
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      part_q <= part_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_part_o  = part_q;

endmodule

// ===== hw/rtl/dtd_sum.sv =====
// Final stage: leap year and day-of-month checks, day count sum and the result register.
// Depends on dtd_pkg.
module dtd_sum
  import dtd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtd_part_t         in_part_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              valid_res_o,
  output logic [CountW-1:0] day_count_o
);

  logic              vld_q;
  logic              res_ok_q, res_ok_d;
  logic [CountW-1:0] count_q, count_d;
  logic [YearW-1:0]  hundreds;
  logic              century;
  logic              leap;
  logic [4:0]        dim;
  logic [8:0]        doy;

  // Leap year: divisible by 4, centuries only when divisible by 400
  assign hundreds = YearW'(in_part_i.year_div100) * YearW'(100);
  assign century  = (hundreds == in_part_i.year);
  assign leap     = (in_part_i.year[1:0] == 2'b00) &&
                    (!century || in_part_i.year_div100[1:0] == 2'b00);

  assign dim = month_len(in_part_i.month) +
               5'((in_part_i.month == 4'd2) && leap);
  assign doy = days_before(in_part_i.month) + 9'(in_part_i.day) +
               9'(leap && in_part_i.month > 4'd2);

  // Sum the elapsed days; force zero when the date is invalid
  always_comb begin
    res_ok_d = in_part_i.ok && (in_part_i.day <= FieldW'(dim));
    count_d  = in_part_i.prev_x365 + CountW'(in_part_i.prev_year >> 2)
             - CountW'(in_part_i.prev_div100) + CountW'(in_part_i.prev_div100 >> 2)
             + CountW'(doy);
    if (!res_ok_d) begin
      count_d = '0;
    end
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_ok_q <= res_ok_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o = vld_q;
  assign valid_res_o = res_ok_q;
  assign day_count_o = count_q;

endmodule

// ===== bench/date_text_to_day_number_tb.sv =====
// Testbench for date_text_to_day_number: streams date strings and checks the day numbers.
// Self-contained predictor, directed table plus random strings; depends on dtd_pkg and the RTL.
`timescale 1ns / 100ps

module date_text_to_day_number_tb
  import dtd_pkg::*;
();

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned ItemBudget   = 1800;

  // Parse positions inside one date string
  typedef enum logic [2:0] {
    PosYear, PosMon1, PosMon2, PosDash2, PosDay1, PosDay2, PosDone
  } parse_pos_e;

  typedef enum logic [0:0] {RowText, RowCfg} row_kind_e;

  typedef struct packed {
    logic        valid;
    logic [21:0] days;
  } day_result_t;

  // One directed row: a string (plus optional raw final byte) or a year floor write
  typedef struct packed {
    row_kind_e        kind;
    logic [8*14-1:0]  text;
    logic             tail_en;
    logic [7:0]       tail;
    logic             typed;
    logic             exp_valid;
    logic [21:0]      exp_days;
    logic [YearW-1:0] cfg_val;
  } dir_row_t;

  typedef logic [7:0] char_q_t [$];

  localparam int unsigned DirRows = 27;
  localparam dir_row_t DirTab [DirRows] = '{
    '{RowText, "1900-01-01",    1'b0, 8'h00, 1'b1, 1'b1, 22'd693596,  14'd0},
    '{RowText, "1899-12-31",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2024-02-29",    1'b0, 8'h00, 1'b0, 1'b0, 22'd0,       14'd0},
    '{RowText, "2023-02-29",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "1900-02-29",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2000-02-29",    1'b0, 8'h00, 1'b0, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-13-01",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-00-10",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-04-31",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-04-00",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "-01-01",        1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-04",       1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "10000-01-01",   1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "20a1-01-01",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-0",        1'b1, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-04-05",    1'b1, 8'hFF, 1'b0, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021-04-05xyz", 1'b0, 8'h00, 1'b0, 1'b0, 22'd0,       14'd0},
    '{RowText, "2021/04/05",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "7",             1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowCfg,  "",              1'b0, 8'h00, 1'b0, 1'b0, 22'd0,       14'd0},
    '{RowText, "0000-01-01",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "0001-01-01",    1'b0, 8'h00, 1'b1, 1'b1, 22'd1,       14'd0},
    '{RowText, "1-01-01",       1'b0, 8'h00, 1'b1, 1'b1, 22'd1,       14'd0},
    '{RowText, "9999-12-31",    1'b0, 8'h00, 1'b1, 1'b1, 22'd3652059, 14'd0},
    '{RowCfg,  "",              1'b0, 8'h00, 1'b0, 1'b0, 22'd0,       14'd9999},
    '{RowText, "9998-12-31",    1'b0, 8'h00, 1'b1, 1'b0, 22'd0,       14'd0},
    '{RowText, "9999-01-01",    1'b0, 8'h00, 1'b0, 1'b0, 22'd0,       14'd0}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [YearW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;
  logic             m_axis_tuser;

  // Predictor state
  parse_pos_e       parse_pos    = PosYear;
  logic [YearW-1:0] year_acc     = '0;
  logic             year_ovf     = 1'b0;
  logic             year_seen    = 1'b0;
  logic [6:0]       mon_acc      = '0;
  logic [6:0]       day_acc      = '0;
  logic             bad_syntax   = 1'b0;
  logic [YearW-1:0] year_floor_q = MinYearReset;

  day_result_t pending_days [$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          rx_hold        = 0;
  bit          idle_on        = 1'b1;
  int          chars_sent     = 0;

  date_text_to_day_number dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Month length with the Gregorian leap rule; 0 for a code that is no month
  function automatic int month_days(input int y, input int m);
    int len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2: len = (y % 400 == 0 || (y % 100 != 0 && y % 4 == 0)) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Days from 0001-01-01 (day 1) to the given date
  function automatic logic [21:0] ordinal_day(input int y, input int m, input int d);
    int py;
    int n;
    py = y - 1;
    n  = d + 365 * py + py / 4 - py / 100 + py / 400;
    for (int k = 1; k < m; k++) n += month_days(y, k);
    return 22'(n);
  endfunction

  // Advance the parse by one character; on the final one, produce the result
  task automatic parse_date_char(input logic [7:0] c, input logic is_last,
                                 output day_result_t res);
    logic dig;
    int   dv;
    int   nv;
    logic ok;
    dig = (c >= ChZero) && (c <= ChNine);
    dv  = dig ? int'(c - ChZero) : 0;
    res = '0;
    if (!bad_syntax) begin
      case (parse_pos)
        PosYear: begin
          if (dig) begin
            year_seen = 1'b1;
            nv = int'(year_acc) * 10 + dv;
            if (year_ovf || nv > int'(MaxYear)) begin
              year_ovf = 1'b1;
              year_acc = MaxYear;
            end else begin
              year_acc = YearW'(nv);
            end
          end else if (c == ChDash && year_seen) begin
            parse_pos = PosMon1;
          end else begin
            bad_syntax = 1'b1;
          end
        end
        PosMon1: if (dig) begin
          mon_acc = 7'(dv * 10); parse_pos = PosMon2;
        end else bad_syntax = 1'b1;
        PosMon2: if (dig) begin
          mon_acc = mon_acc + 7'(dv); parse_pos = PosDash2;
        end else bad_syntax = 1'b1;
        PosDash2: if (c == ChDash) parse_pos = PosDay1; else bad_syntax = 1'b1;
        PosDay1: if (dig) begin
          day_acc = 7'(dv * 10); parse_pos = PosDay2;
        end else bad_syntax = 1'b1;
        PosDay2: if (dig) begin
          day_acc = day_acc + 7'(dv); parse_pos = PosDone;
        end else bad_syntax = 1'b1;
        default: ;
      endcase
    end
    if (is_last) begin
      ok = !bad_syntax && parse_pos == PosDone && !year_ovf && year_acc >= 1 &&
           year_acc >= year_floor_q && mon_acc >= 1 && mon_acc <= 12 && day_acc >= 1 &&
           int'(day_acc) <= month_days(int'(year_acc), int'(mon_acc));
      res.valid = ok;
      res.days  = ok ? ordinal_day(int'(year_acc), int'(mon_acc), int'(day_acc)) : '0;
      parse_pos  = PosYear;
      year_acc   = '0;
      year_ovf   = 1'b0;
      year_seen  = 1'b0;
      mon_acc    = '0;
      day_acc    = '0;
      bad_syntax = 1'b0;
    end
  endtask

  // Send one string; queue the typed result if given, else the predicted one
  task automatic send_date_text(input char_q_t txt, input logic use_typed,
                                input day_result_t typed_res);
    day_result_t res;
    for (int i = 0; i < txt.size(); i++) begin
      // random gap before the transfer
      if (idle_on && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= txt[i];
      s_axis_tlast  <= (i == txt.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      chars_sent++;
      parse_date_char(txt[i], i == txt.size() - 1, res);
    end
    pending_days.push_back(use_typed ? typed_res : res);
  endtask

  // Hold the sender until every result is back, then write the year floor
  task automatic load_year_floor(input logic [YearW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_days.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    year_floor_q = val;
  endtask

  // Random string: mostly well-formed dates, some broken, some pure noise
  task automatic make_date_text(output char_q_t txt);
    int kind;
    int y;
    int m;
    int d;
    int v;
    int w;
    int n;
    txt  = {};
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 12);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 4))
      0: y = $urandom_range(1, 9999);
      1: y = int'(year_floor_q) + int'($urandom_range(0, 4)) - 2;
      2: y = 100 * $urandom_range(0, 99);
      3: y = 4 * $urandom_range(0, 2499);
      default: y = ($urandom_range(0, 3) == 0) ? $urandom_range(10000, 99999)
                                                : $urandom_range(1800, 2200);
    endcase
    if (y < 0) y = 0;
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0, 1, 2: d = month_days(y, m) + $urandom_range(0, 1);
      3:       d = $urandom_range(0, 99);
      default: d = $urandom_range(1, 31);
    endcase
    // year digits, sometimes with leading zeros
    w = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : 1;
    v = y;
    do begin
      txt.push_front(ChZero + 8'(v % 10));
      v = v / 10;
    end while (v > 0 || txt.size() < w);
    txt.push_back(ChDash);
    txt.push_back(ChZero + 8'(m / 10));
    txt.push_back(ChZero + 8'(m % 10));
    txt.push_back(ChDash);
    txt.push_back(ChZero + 8'(d / 10));
    txt.push_back(ChZero + 8'(d % 10));
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end
    // break some of the well-formed strings
    if (kind < 20) begin
      n = $urandom_range(1, txt.size() - 1);
      while (txt.size() > n) void'(txt.pop_back());
    end else if (kind < 28) begin
      txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  // Result side: check each transfer, stall in random bursts, watch for a hang
  always @(posedge clk_i) begin : result_side
    day_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_days.size() == 0) begin
          $display("%0t: unexpected result: valid_res %0b day_count %0d", $time,
                   m_axis_tuser, m_axis_tdata[21:0]);
          mismatch_count++;
        end else begin
          want = pending_days.pop_front();
          if (m_axis_tuser !== want.valid) begin
            $display("%0t: valid_res mismatch: expected %0b, got %0b", $time,
                     want.valid, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata !== {2'b00, want.days}) begin
            $display("%0t: day_count mismatch: expected %0d, got %0d", $time,
                     want.days, m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        rx_hold = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    char_q_t          txt;
    day_result_t      typed_res;
    logic [YearW-1:0] phase_min;
    int               budget;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < DirRows; r++) begin
      if (DirTab[r].kind == RowCfg) begin
        load_year_floor(DirTab[r].cfg_val);
      end else begin
        txt = {};
        for (int b = 13; b >= 0; b--) begin
          if (DirTab[r].text[b*8 +: 8] != 8'h00) txt.push_back(DirTab[r].text[b*8 +: 8]);
        end
        if (DirTab[r].tail_en) txt.push_back(DirTab[r].tail);
        typed_res.valid = DirTab[r].exp_valid;
        typed_res.days  = DirTab[r].exp_days;
        send_date_text(txt, DirTab[r].typed, typed_res);
      end
    end

    // random phases, each under its own year floor; the second and the last without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       phase_min = '0;
        1:       phase_min = YearW'($urandom_range(1, 9999));
        2:       phase_min = MaxYear;
        3:       phase_min = '1;
        4:       phase_min = YearW'($urandom_range(1500, 2100));
        default: phase_min = MinYearReset;
      endcase
      load_year_floor(phase_min);
      idle_on = (ph != 1) && (ph != 5);
      budget  = chars_sent + ((ph == 3) ? 80 : 340);
      if (ph == 5) budget = ItemBudget;
      while (chars_sent < budget) begin
        make_date_text(txt);
        send_date_text(txt, 1'b0, '0);
      end
    end

    // drain and finish
    s_axis_tvalid <= 1'b0;
    while (pending_days.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_parse.sv
hw/rtl/dtd_calc.sv
hw/rtl/dtd_sum.sv
hw/rtl/date_text_to_day_number.sv
bench/date_text_to_day_number_tb.sv
